// ----- rtl/gsb_pkg.sv -----
// gsb_pkg: shared types, grid constants and gain tables for the gain schedule block.
// No dependencies.
package gsb_pkg;

	localparam int TAB_W        = 24;
	localparam int DIFF_W       = 20;
	localparam int ROLL_STEP_Q  = 3840;
	localparam int PITCH_STEP_Q = 5120;
	localparam int ROLL_SHIFT   = 8;
	localparam int ROLL_ODD     = 15;
	localparam int PITCH_SHIFT  = 10;
	localparam int PITCH_ODD    = 5;
	localparam int PIPE_DEPTH   = 11;

	typedef enum logic [1:0] {
		GAIN_KP = 2'd0,
		GAIN_KD = 2'd1,
		GAIN_KI = 2'd2
	} gain_t;

	typedef struct packed {
		logic axis;
		logic rsel;
		logic psel;
	} seg_t;

	typedef logic [TAB_W-1:0] tab_t;
	typedef tab_t grid_t [3][3];

	// rows: pitch -20/0/+20, columns: roll -15/0/+15, Q.16
	localparam grid_t KP_ROLL = '{
		'{24'd8874230, 24'd8874230, 24'd9038070},
		'{24'd8927969, 24'd8665825, 24'd8527544},
		'{24'd9002025, 24'd8897823, 24'd8636334}
	};
	localparam grid_t KD_ROLL = '{
		'{24'd42775, 24'd70969, 24'd28682},
		'{24'd44918, 24'd49729, 24'd31523},
		'{24'd43116, 24'd70700, 24'd27881}
	};
	localparam grid_t KP_PITCH = '{
		'{24'd12148408, 24'd12148408, 24'd12148408},
		'{24'd10837688, 24'd10837688, 24'd10837688},
		'{24'd10837688, 24'd10837688, 24'd10837688}
	};
	localparam grid_t KD_PITCH = '{
		'{24'd24058, 24'd24058, 24'd24058},
		'{24'd24058, 24'd24058, 24'd24058},
		'{24'd24058, 24'd24058, 24'd24058}
	};
	localparam grid_t KI_PITCH = '{
		'{24'd12167, 24'd12167, 24'd12167},
		'{24'd10201, 24'd10201, 24'd10201},
		'{24'd10201, 24'd10201, 24'd10201}
	};

	// roll axis has no integral table: reads as zero
	function automatic tab_t tab_rd(input gain_t g, input logic ax,
		input logic [1:0] row, input logic [1:0] col);
		tab_t v;
		unique case (g)
			GAIN_KP: v = ax ? KP_PITCH[row][col] : KP_ROLL[row][col];
			GAIN_KD: v = ax ? KD_PITCH[row][col] : KD_ROLL[row][col];
			GAIN_KI: v = ax ? KI_PITCH[row][col] : '0;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/gsb_rdiv.sv -----
// gsb_rdiv: signed divide by (DIVISOR << SHIFT), round to nearest, ties away from zero.
// Two register stages: reciprocal multiply, then one-step correction. Uses no package.
module gsb_rdiv #(
	parameter int NW = 37,
	parameter int SHIFT = 8,
	parameter int DIVISOR = 15,
	localparam int UW = NW + 1 - SHIFT
) (
	input  logic                 clk,
	input  logic signed [NW-1:0] n,
	output logic signed [UW-1:0] q
);

	localparam int K  = UW;
	localparam int RW = UW - 1;
	localparam int PW = UW + RW;
	localparam logic [K:0]    POW   = {1'b1, {K{1'b0}}};
	localparam logic [RW-1:0] RECIP = RW'(POW / (K + 1)'(DIVISOR));
	localparam logic [NW:0]   HALF  = (NW + 1)'(DIVISOR) << (SHIFT - 1);
	localparam logic [4:0]    D5    = 5'(DIVISOR);

	logic [NW:0]   nx;
	logic [NW:0]   rnd;
	logic [UW-1:0] u;
	logic [PW-1:0] prod_s1;
	logic [UW-1:0] u_s1;
	logic          neg_s1;
	logic [RW-1:0] q0;
	logic [4:0]    dq;
	logic [4:0]    rem;
	logic [RW-1:0] qm;
	logic signed [UW-1:0] q_s2;

	// |n| + half, then drop the power-of-two part of the divisor
	assign nx  = {n[NW-1], n};
	assign rnd = n[NW-1] ? (HALF - nx) : (HALF + nx);
	assign u   = rnd[NW:SHIFT];

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(u) * PW'(RECIP);
		u_s1    <= u;
		neg_s1  <= n[NW-1];
	end

	// estimate is exact or one low
	assign q0  = prod_s1[PW-1:K];
	assign dq  = q0[4:0] * D5;
	assign rem = u_s1[4:0] - dq;
	assign qm  = q0 + {{(RW - 1){1'b0}}, (rem >= D5)};

	always_ff @(posedge clk) begin
		q_s2 <= neg_s1 ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
	end

	assign q = q_s2;

endmodule

// ----- rtl/gsb_lane.sv -----
// gsb_lane: one gain lane; table lookup, roll interpolation, pitch interpolation, saturation.
// Depends on gsb_pkg and gsb_rdiv. Lane stages s2..s11, result registered at s11.
module gsb_lane import gsb_pkg::*; #(
	parameter int ANGLE_WIDTH = 16,
	parameter int GAIN_WIDTH = 26,
	parameter gain_t GAIN = GAIN_KP,
	localparam int OW = (ANGLE_WIDTH + 1 > 14) ? ANGLE_WIDTH + 1 : 14
) (
	input  logic                  clk,
	input  seg_t                  seg_s1,
	input  logic signed [OW-1:0]  roff_s1,
	input  logic signed [OW-1:0]  poff_s1,
	output logic [GAIN_WIDTH-1:0] gain
);

	localparam int NRW = DIFF_W + OW;
	localparam int QRW = NRW + 1 - ROLL_SHIFT;
	localparam int LW  = ((ANGLE_WIDTH + 9 > TAB_W + 1) ? ANGLE_WIDTH + 9 : TAB_W + 1) + 1;
	localparam int DFW = ANGLE_WIDTH + 11;
	localparam int NPW = DFW + OW;
	localparam int QPW = NPW + 1 - PITCH_SHIFT;
	localparam int SW  = ((LW > QPW) ? LW : QPW) + 1;
	localparam int EW  = (SW > GAIN_WIDTH + 1) ? SW : GAIN_WIDTH + 1;
	localparam logic signed [EW-1:0] GMAX = EW'({GAIN_WIDTH{1'b1}});

	logic [1:0] row_lo, row_hi, col_lo, col_hi;
	tab_t t00, t01, t10, t11;
	logic signed [TAB_W:0] d0_full, d1_full;

	tab_t t00_s2, t10_s2, t00_s3, t10_s3, t00_s4, t10_s4, t00_s5, t10_s5;
	logic signed [DIFF_W-1:0] d0_s2, d1_s2;
	logic signed [OW-1:0] roff_s2;
	logic signed [OW-1:0] poff_s2, poff_s3, poff_s4, poff_s5, poff_s6, poff_s7;
	logic signed [NRW-1:0] n0_s3, n1_s3;
	logic signed [QRW-1:0] q0, q1;
	logic signed [LW-1:0] lo_s6, hi_s6, lo_s7, lo_s8, lo_s9, lo_s10;
	logic signed [DFW-1:0] diff_s7;
	logic signed [NPW-1:0] np_s8;
	logic signed [QPW-1:0] term;
	logic signed [SW-1:0] sum;
	logic signed [EW-1:0] sx;
	logic [GAIN_WIDTH-1:0] gsat;
	logic [GAIN_WIDTH-1:0] gain_s11;

	// s2: corner lookup
	assign row_lo = {1'b0, seg_s1.psel};
	assign row_hi = row_lo + 2'd1;
	assign col_lo = {1'b0, seg_s1.rsel};
	assign col_hi = col_lo + 2'd1;
	assign t00 = tab_rd(GAIN, seg_s1.axis, row_lo, col_lo);
	assign t01 = tab_rd(GAIN, seg_s1.axis, row_lo, col_hi);
	assign t10 = tab_rd(GAIN, seg_s1.axis, row_hi, col_lo);
	assign t11 = tab_rd(GAIN, seg_s1.axis, row_hi, col_hi);
	assign d0_full = $signed({1'b0, t01}) - $signed({1'b0, t00});
	assign d1_full = $signed({1'b0, t11}) - $signed({1'b0, t10});

	always_ff @(posedge clk) begin
		t00_s2  <= t00;
		t10_s2  <= t10;
		d0_s2   <= DIFF_W'(d0_full);
		d1_s2   <= DIFF_W'(d1_full);
		roff_s2 <= roff_s1;
		poff_s2 <= poff_s1;
	end

	// s3: roll products
	always_ff @(posedge clk) begin
		n0_s3   <= NRW'(d0_s2) * NRW'(roff_s2);
		n1_s3   <= NRW'(d1_s2) * NRW'(roff_s2);
		t00_s3  <= t00_s2;
		t10_s3  <= t10_s2;
		poff_s3 <= poff_s2;
	end

	// s4, s5: roll division
	gsb_rdiv #(.NW(NRW), .SHIFT(ROLL_SHIFT), .DIVISOR(ROLL_ODD)) u_rdiv_lo (
		.clk (clk),
		.n   (n0_s3),
		.q   (q0)
	);

	gsb_rdiv #(.NW(NRW), .SHIFT(ROLL_SHIFT), .DIVISOR(ROLL_ODD)) u_rdiv_hi (
		.clk (clk),
		.n   (n1_s3),
		.q   (q1)
	);

	always_ff @(posedge clk) begin
		t00_s4  <= t00_s3;
		t10_s4  <= t10_s3;
		poff_s4 <= poff_s3;
		t00_s5  <= t00_s4;
		t10_s5  <= t10_s4;
		poff_s5 <= poff_s4;
	end

	// s6: roll results on both rows
	always_ff @(posedge clk) begin
		lo_s6   <= LW'($signed({1'b0, t00_s5})) + LW'(q0);
		hi_s6   <= LW'($signed({1'b0, t10_s5})) + LW'(q1);
		poff_s6 <= poff_s5;
	end

	// s7, s8: pitch product
	always_ff @(posedge clk) begin
		diff_s7 <= DFW'(hi_s6 - lo_s6);
		lo_s7   <= lo_s6;
		poff_s7 <= poff_s6;
		np_s8   <= NPW'(diff_s7) * NPW'(poff_s7);
		lo_s8   <= lo_s7;
	end

	// s9, s10: pitch division
	gsb_rdiv #(.NW(NPW), .SHIFT(PITCH_SHIFT), .DIVISOR(PITCH_ODD)) u_rdiv_p (
		.clk (clk),
		.n   (np_s8),
		.q   (term)
	);

	always_ff @(posedge clk) begin
		lo_s9  <= lo_s8;
		lo_s10 <= lo_s9;
	end

	// s11: final sum and clamp
	assign sum = SW'(lo_s10) + SW'(term);
	assign sx  = EW'(sum);

	always_comb begin
		if (sx[EW-1]) begin
			gsat = '0;
		end else if (sx > GMAX) begin
			gsat = GAIN_WIDTH'(GMAX);
		end else begin
			gsat = GAIN_WIDTH'(sx);
		end
	end

	always_ff @(posedge clk) begin
		gain_s11 <= gsat;
	end

	assign gain = gain_s11;

endmodule

// ----- rtl/gain_schedule_bilinear_unit.sv -----
// gain_schedule_bilinear_unit: scheduled PID gains by bilinear interpolation, top level.
// Depends on gsb_pkg, gsb_lane, gsb_rdiv.
//
// channel   dir  signals                          handshake
// command   in   axis, roll_deg, pitch_deg        taken when start && !busy
// result    out  kp, kd, ki                       shown for one cycle with done
//
// One item enters per cycle; busy never rises.
// Each result passes through 11 register stages after its item is taken, the roll
// and pitch constant-divide units taking two each.
// Reset clears only the valid pipeline; payload stages free-run.
// The receiver cannot stall, so the pipeline never holds.
module gain_schedule_bilinear_unit import gsb_pkg::*; #(
	parameter int ANGLE_WIDTH = 16,
	parameter int GAIN_WIDTH = 26
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          axis,
	input  logic signed [ANGLE_WIDTH-1:0] roll_deg,
	input  logic signed [ANGLE_WIDTH-1:0] pitch_deg,
	output logic                          done,
	output logic [GAIN_WIDTH-1:0]         kp,
	output logic [GAIN_WIDTH-1:0]         kd,
	output logic [GAIN_WIDTH-1:0]         ki
);

	localparam int OW = (ANGLE_WIDTH + 1 > 14) ? ANGLE_WIDTH + 1 : 14;
	localparam logic signed [OW-1:0] RSTEP = OW'(ROLL_STEP_Q);
	localparam logic signed [OW-1:0] PSTEP = OW'(PITCH_STEP_Q);

	logic                 accept;
	logic signed [OW-1:0] rx, px, roff, poff;
	logic                 rsel, psel;
	seg_t                 seg_s1;
	logic signed [OW-1:0] roff_s1, poff_s1;
	logic [PIPE_DEPTH-1:0] vld_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// upper segment only for 0 < angle <= step, else lower segment (extrapolates)
	assign rx   = OW'(roll_deg);
	assign px   = OW'(pitch_deg);
	assign rsel = !rx[OW-1] && (rx != '0) && (rx <= RSTEP);
	assign psel = !px[OW-1] && (px != '0) && (px <= PSTEP);
	assign roff = rsel ? rx : rx + RSTEP;
	assign poff = psel ? px : px + PSTEP;

	always_ff @(posedge clk) begin
		seg_s1  <= '{axis: axis, rsel: rsel, psel: psel};
		roff_s1 <= roff;
		poff_s1 <= poff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
		end
	end

	gsb_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .GAIN_WIDTH(GAIN_WIDTH), .GAIN(GAIN_KP)) u_lane_kp (
		.clk     (clk),
		.seg_s1  (seg_s1),
		.roff_s1 (roff_s1),
		.poff_s1 (poff_s1),
		.gain    (kp)
	);

	gsb_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .GAIN_WIDTH(GAIN_WIDTH), .GAIN(GAIN_KD)) u_lane_kd (
		.clk     (clk),
		.seg_s1  (seg_s1),
		.roff_s1 (roff_s1),
		.poff_s1 (poff_s1),
		.gain    (kd)
	);

	gsb_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .GAIN_WIDTH(GAIN_WIDTH), .GAIN(GAIN_KI)) u_lane_ki (
		.clk     (clk),
		.seg_s1  (seg_s1),
		.roff_s1 (roff_s1),
		.poff_s1 (poff_s1),
		.gain    (ki)
	);

	assign done = vld_q[PIPE_DEPTH-1];

	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_DEPTH))
		else $error("result without a matching item");

	a_item_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_DEPTH done)
		else $error("item taken but no result after pipeline latency");

	a_roll_ki_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(axis, PIPE_DEPTH)) |-> (ki == '0))
		else $error("roll axis result with nonzero ki");

endmodule
